[rtl/dcs_pkg.sv]
// Package for the discrete CDF sampler: sizing constants, opcode and status
// codes, and the transaction and table entry types.
// No dependencies.
`timescale 1ns / 1ps

package dcs_pkg;

  localparam int unsigned MAX_WEIGHTS   = 256;
  localparam int unsigned FRAC_BITS     = 32;
  localparam int unsigned SUM_TOLERANCE = 43;

  localparam int unsigned FX_W    = 33;                       // value field width
  localparam int unsigned IDX_W   = 8;                        // index field width
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned ECNT_W  = 9;                        // entry_count field width
  localparam int unsigned ADDR_W  = $clog2(MAX_WEIGHTS);
  localparam int unsigned CNT_W   = $clog2(MAX_WEIGHTS + 1);

  localparam logic [FX_W:0]   ONE_WIDE   = (FX_W + 1)'(1) << FRAC_BITS;
  localparam logic [FX_W:0]   OVER_LIMIT = ONE_WIDE + (FX_W + 1)'(SUM_TOLERANCE);
  localparam logic [FX_W-1:0] ONE_FX     = FX_W'(1) << FRAC_BITS;
  localparam logic [FX_W-1:0] UNDER_LIMIT = ONE_FX - FX_W'(SUM_TOLERANCE);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SAMPLE = 2'd2
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVER      = 3'd1,
    ST_UNDER     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_READY = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [FX_W-1:0] weight;
    logic            last_weight;
    logic [FX_W-1:0] uniform;
  } dcs_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [STAT_W-1:0] status;
    logic [ECNT_W-1:0] entry_count;
  } dcs_out_t;

  typedef struct packed {
    logic [FX_W-1:0]  key;
    logic [IDX_W-1:0] idx;
  } dcs_entry_t;

endpackage

[rtl/discrete_cdf_sampler_top.sv]
// Top level of the discrete CDF sampler: control, running sum and the
// cumulative key table memory with its binary search.
// Depends on dcs_pkg.
`timescale 1ns / 1ps

// The sampler takes one transaction at a time on the input channel and
// returns exactly one result transaction for each. A clear transaction
// empties the table, load transactions append cumulative keys (fixed point,
// 2^32 is 1.0) together with the weight's input index, and a sample
// transaction maps a uniform value to the index of the first key above it;
// a zero uniform gives index 0, and a value with no key above it the last
// entry. For clear, load and unknown opcodes the result is registered and
// then moves into the output register once that is free. A sample first
// searches the key memory with one read per cycle, and a final read fetches
// the chosen entry's index. Samples that need no search (not ready, zero
// uniform, empty table) skip both the search and the fetch.
// The output register decouples the sides, so the next input transaction is
// accepted while an earlier result still waits for the consumer. The key
// memory needs no clearing after reset: only entries below the entry count
// are ever read.
module discrete_cdf_sampler_top
  import dcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dcs_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dcs_out_t out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  // Table state.
  logic [FX_W-1:0]  running_sum_q, running_sum_d;
  logic [CNT_W-1:0] weights_seen_q, weights_seen_d;
  logic [CNT_W-1:0] entries_q, entries_d;
  logic             complete_q, complete_d;
  logic             error_q, error_d;

  // Search state and pending result.
  logic [FX_W-1:0]   uni_q, uni_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [ADDR_W-1:0] mid_q, mid_d;
  logic [IDX_W-1:0]  res_index_q, res_index_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;

  // Output register.
  logic     out_valid_q, out_valid_d;
  dcs_out_t out_q, out_d;

  // Key memory: one write port, one read port with registered data.
  dcs_entry_t        cdf_mem_q [MAX_WEIGHTS];
  dcs_entry_t        rd_data_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  dcs_entry_t        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic in_fire;

  // Load datapath.
  logic [FX_W:0]    sum_wide;
  logic [FX_W-1:0]  sum_clamp;
  logic [FX_W-1:0]  sum_after;
  logic             weight_nz;
  logic             over_one;
  logic             dup_key;
  logic             under_one;
  logic             table_full;
  logic [CNT_W+IDX_W-1:0]  seen_wide;
  logic [CNT_W+ECNT_W-1:0] entries_wide;

  // Search datapath.
  logic [FX_W-1:0]  uni_sat;
  logic             key_gt;
  logic [CNT_W-1:0] lo_n;
  logic [CNT_W-1:0] hi_n;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W:0]   mid_half;
  logic [CNT_W-1:0] entries_half;
  logic [CNT_W-1:0] pos_full;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign sum_wide   = {1'b0, running_sum_q} + {1'b0, in_i.weight};
  assign over_one   = sum_wide > OVER_LIMIT;
  assign sum_clamp  = (sum_wide > ONE_WIDE) ? ONE_FX : sum_wide[FX_W-1:0];
  assign weight_nz  = (in_i.weight != '0);
  // The last stored key always equals the running sum, so a duplicate key is
  // a clamped sum that did not move.
  assign dup_key    = (sum_clamp == running_sum_q);
  assign sum_after  = weight_nz ? sum_clamp : running_sum_q;
  assign under_one  = sum_after < UNDER_LIMIT;
  assign table_full = (weights_seen_q >= CNT_W'(MAX_WEIGHTS));
  assign seen_wide    = {{IDX_W{1'b0}}, weights_seen_q};
  assign entries_wide = {{ECNT_W{1'b0}}, entries_q};

  assign uni_sat      = (in_i.uniform > ONE_FX) ? ONE_FX : in_i.uniform;
  assign entries_half = entries_q >> 1;

  // One step of the lower-bound search: find the first key above uniform.
  assign key_gt   = rd_data_q.key > uni_q;
  assign lo_n     = key_gt ? lo_q : (CNT_W'(mid_q) + CNT_W'(1));
  assign hi_n     = key_gt ? CNT_W'(mid_q) : hi_q;
  assign mid_sum  = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_half = mid_sum >> 1;
  // No key above uniform (this includes uniform equal to one) selects the
  // last entry.
  assign pos_full = (lo_n == entries_q) ? (entries_q - CNT_W'(1)) : lo_n;

  always_comb begin
    state_d        = state_q;
    running_sum_d  = running_sum_q;
    weights_seen_d = weights_seen_q;
    entries_d      = entries_q;
    complete_d     = complete_q;
    error_d        = error_q;
    uni_d          = uni_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    mid_d          = mid_q;
    res_index_d    = res_index_q;
    res_status_d   = res_status_q;
    out_valid_d    = out_valid_q;
    out_d          = out_q;
    mem_we         = 1'b0;
    mem_waddr      = entries_q[ADDR_W-1:0];
    mem_wdata.key  = sum_clamp;
    mem_wdata.idx  = seen_wide[IDX_W-1:0];
    mem_re         = 1'b0;
    mem_raddr      = mid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_index_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_FINISH;
          case (in_i.opcode)
            OP_CLEAR: begin
              running_sum_d  = '0;
              weights_seen_d = '0;
              entries_d      = '0;
              complete_d     = 1'b0;
              error_d        = 1'b0;
            end
            OP_LOAD: begin
              if (complete_q || error_q) begin
                res_status_d = ST_NOT_READY;
              end else if (table_full) begin
                error_d      = 1'b1;
                res_status_d = ST_FULL;
              end else if (weight_nz && over_one) begin
                error_d      = 1'b1;
                res_status_d = ST_OVER;
              end else begin
                if (weight_nz) begin
                  running_sum_d = sum_clamp;
                  if (!dup_key && (entries_q < CNT_W'(MAX_WEIGHTS))) begin
                    mem_we    = 1'b1;
                    entries_d = entries_q + CNT_W'(1);
                  end
                end
                weights_seen_d = weights_seen_q + CNT_W'(1);
                if (in_i.last_weight) begin
                  if (under_one) begin
                    error_d      = 1'b1;
                    res_status_d = ST_UNDER;
                  end else begin
                    complete_d = 1'b1;
                  end
                end
              end
            end
            OP_SAMPLE: begin
              if (!complete_q || error_q) begin
                res_status_d = ST_NOT_READY;
              end else if ((uni_sat != '0) && (entries_q != '0)) begin
                uni_d     = uni_sat;
                lo_d      = '0;
                hi_d      = entries_q;
                mid_d     = entries_half[ADDR_W-1:0];
                mem_re    = 1'b1;
                mem_raddr = entries_half[ADDR_W-1:0];
                state_d   = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SEARCH: begin
        lo_d   = lo_n;
        hi_d   = hi_n;
        mem_re = 1'b1;
        if (lo_n == hi_n) begin
          mem_raddr = pos_full[ADDR_W-1:0];
          state_d   = S_FETCH;
        end else begin
          mid_d     = mid_half[ADDR_W-1:0];
          mem_raddr = mid_half[ADDR_W-1:0];
        end
      end

      S_FETCH: begin
        res_index_d = rd_data_q.idx;
        state_d     = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.index       = res_index_q;
          out_d.status      = res_status_q;
          out_d.entry_count = entries_wide[ECNT_W-1:0];
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      running_sum_q  <= '0;
      weights_seen_q <= '0;
      entries_q      <= '0;
      complete_q     <= 1'b0;
      error_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      running_sum_q  <= running_sum_d;
      weights_seen_q <= weights_seen_d;
      entries_q      <= entries_d;
      complete_q     <= complete_d;
      error_q        <= error_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    uni_q        <= uni_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    res_index_q  <= res_index_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  // Writes happen only when a load transaction is accepted and reads only
  // during a sample, so the two ports never touch the same entry in one
  // cycle and no forwarding path is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cdf_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= cdf_mem_q[mem_raddr];
    end
  end

  // Every stored entry came from a counted weight.
  a_entries_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q <= weights_seen_q)
    else $error("entry count exceeds the number of weights seen");

  // A finished load and a failed load exclude each other.
  a_complete_xor_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(complete_q && error_q))
    else $error("load flagged both complete and failed");

  // The search interval never collapses while a probe is outstanding.
  a_search_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (lo_q < hi_q) && (CNT_W'(mid_q) < hi_q))
    else $error("search interval is empty or probe is out of range");

  // The table is only written on an accepted transaction, never mid-search.
  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (in_fire && (state_q == S_IDLE)))
    else $error("key memory written outside an accepted load");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for discrete_cdf_sampler_top: directed table, scripted
// full-table runs and random load/sample sequences under random flow control.
// Depends on dcs_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
  import dcs_pkg::*;

  // Opcode 3 has no meaning in the package; the block must answer it with a
  // plain OK result and leave its state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // 1.0 in the block's fixed point format, kept wide for the arithmetic below.
  localparam longint unsigned FX_ONE = 64'd1 << FRAC_BITS;

  // Shapes of a random load sequence.
  typedef enum int {
    SEQ_CLEAN,    // sum ends within the tolerance of 1.0
    SEQ_SHORT,    // sum ends below 1.0 by more than the tolerance
    SEQ_OVERRUN,  // one weight pushes the sum past 1.0 by more than the tolerance
    SEQ_OPEN      // no final weight is marked
  } seq_kind_e;

  // A row of the directed table. Where fixed is set, the result is typed in
  // and used instead of the predicted one.
  typedef struct {
    dcs_in_t  item;
    bit       fixed;
    dcs_out_t result;
  } directed_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  dcs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dcs_out_t out_data;

  // Flow control of the current phase, in percent of cycles.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Own copy of the sampler state, updated once per accepted input transaction.
  longint unsigned cdf_keys [MAX_WEIGHTS];
  logic [7:0]      cdf_index [MAX_WEIGHTS];
  longint unsigned cdf_sum        = 0;
  int unsigned     weights_seen   = 0;
  int unsigned     entries_stored = 0;
  bit              load_done      = 1'b0;
  bit              load_failed    = 1'b0;

  // Results still owed by the block, oldest first.
  dcs_out_t      pending_results[$];
  directed_row_t directed_rows[$];
  int unsigned   sent_items = 0;
  int unsigned   failures   = 0;

  discrete_cdf_sampler_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs. The slowest legal run is well under a
  // tenth of this.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Works out the result of one input transaction and advances the state.
  function automatic dcs_out_t sampler_result(input dcs_in_t item);
    dcs_out_t        r;
    longint unsigned sum;
    longint unsigned u;
    bit              found;
    r = '0;
    r.status = ST_OK;
    case (item.opcode)
      OP_CLEAR: begin
        cdf_sum        = 0;
        weights_seen   = 0;
        entries_stored = 0;
        load_done      = 1'b0;
        load_failed    = 1'b0;
      end
      OP_LOAD: begin
        if (load_done || load_failed) begin
          r.status = ST_NOT_READY;
        end else if (weights_seen >= MAX_WEIGHTS) begin
          load_failed = 1'b1;
          r.status    = ST_FULL;
        end else begin
          sum = cdf_sum + item.weight;
          if (item.weight != '0 && sum > FX_ONE && sum - FX_ONE > SUM_TOLERANCE) begin
            load_failed = 1'b1;
            r.status    = ST_OVER;
          end else begin
            // A zero weight only advances the weight index.
            if (item.weight != '0) begin
              if (sum > FX_ONE) sum = FX_ONE;
              cdf_sum = sum;
              // A key equal to the last stored one is dropped.
              if ((entries_stored == 0 || cdf_keys[entries_stored - 1] != sum) &&
                  entries_stored < MAX_WEIGHTS) begin
                cdf_keys[entries_stored]  = sum;
                cdf_index[entries_stored] = weights_seen[7:0];
                entries_stored++;
              end
            end
            weights_seen++;
            if (item.last_weight) begin
              if (FX_ONE - cdf_sum > SUM_TOLERANCE) begin
                load_failed = 1'b1;
                r.status    = ST_UNDER;
              end else begin
                load_done = 1'b1;
              end
            end
          end
        end
      end
      OP_SAMPLE: begin
        if (!load_done || load_failed) begin
          r.status = ST_NOT_READY;
        end else begin
          u = item.uniform;
          if (u > FX_ONE) u = FX_ONE;
          // Zero maps to index 0; 1.0 and values past the last key map to the
          // last entry; anything else to the first key above the value.
          if (u != 0 && entries_stored != 0) begin
            r.index = cdf_index[entries_stored - 1];
            if (u != FX_ONE) begin
              found = 1'b0;
              for (int k = 0; k < entries_stored; k++) begin
                if (!found && cdf_keys[k] > u) begin
                  r.index = cdf_index[k];
                  found   = 1'b1;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.entry_count = entries_stored[ECNT_W-1:0];
    return r;
  endfunction

  function automatic logic [FX_W-1:0] random_fx();
    return {1'($urandom_range(0, 1)), $urandom()};
  endfunction

  function automatic dcs_in_t make_item(input logic [1:0] op, input logic [FX_W-1:0] w,
                                        input logic last, input logic [FX_W-1:0] u);
    dcs_in_t item;
    item.opcode      = op;
    item.weight      = w;
    item.last_weight = last;
    item.uniform     = u;
    return item;
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [FX_W-1:0] w,
                                  input logic last, input logic [FX_W-1:0] u,
                                  input bit fixed, input logic [IDX_W-1:0] idx,
                                  input status_e st, input logic [ECNT_W-1:0] cnt);
    directed_row_t row;
    row.item               = make_item(op, w, last, u);
    row.fixed              = fixed;
    row.result.index       = idx;
    row.result.status      = st;
    row.result.entry_count = cnt;
    directed_rows.push_back(row);
  endfunction

  function automatic void set_idle_phase(input int phase);
    case (phase)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endfunction

  // Drives one input transaction, starting and ending at a falling edge. The
  // valid line gets at most one assignment per time step: it is only lowered
  // when an idle gap is inserted.
  task automatic drive_item(input dcs_in_t item, input bit fixed, input dcs_out_t result);
    dcs_out_t predicted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = sampler_result(item);
    pending_results.push_back(fixed ? result : predicted);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send(input dcs_in_t item);
    drive_item(item, 1'b0, '0);
  endtask

  // Sends n weights shaped by kind. Weights mostly share out what is left of
  // 1.0, with zero weights and early completion of the sum mixed in; after the
  // sum reaches 1.0 the small weights that follow produce duplicate keys.
  task automatic run_load(input int n, input seq_kind_e kind);
    longint remaining;
    longint w;
    int     bad_at;
    int     pick;
    remaining = longint'(FX_ONE);
    bad_at    = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (kind == SEQ_OVERRUN && i == bad_at) begin
        w = remaining + 44 + longint'($urandom_range(0, 1000));
      end else if (i == n - 1 && kind == SEQ_CLEAN) begin
        w = remaining + longint'($urandom_range(0, 86)) - 43;
      end else if (i == n - 1 && kind != SEQ_OPEN) begin
        w = remaining - longint'($urandom_range(44, 5000));
      end else if (pick == 0) begin
        w = 0;
      end else if (pick == 1) begin
        w = (remaining > 43) ? remaining : longint'($urandom_range(0, 43));
      end else begin
        w = (remaining / (n - i)) * longint'($urandom_range(0, 200)) / 100;
        if (w > remaining) w = remaining;
      end
      if (w < 0) w = 0;
      remaining -= w;
      send(make_item(OP_LOAD, w[FX_W-1:0], i == n - 1 && kind != SEQ_OPEN, random_fx()));
    end
  endtask

  // Sends one weight per table entry, each near 1/256 and all nonzero, so that
  // every key is distinct and the last one lands exactly on 1.0.
  task automatic run_full_load();
    longint remaining;
    longint w;
    remaining = longint'(FX_ONE);
    for (int i = 0; i < MAX_WEIGHTS; i++) begin
      if (i == MAX_WEIGHTS - 1)
        w = remaining;
      else
        w = longint'(FX_ONE >> 8) - 1000 + longint'($urandom_range(0, 2000));
      remaining -= w;
      send(make_item(OP_LOAD, w[FX_W-1:0], i == MAX_WEIGHTS - 1, random_fx()));
    end
  endtask

  // Sends sample transactions: random values, stored keys and their
  // neighbors, zero, exactly 1.0 and values above 1.0.
  task automatic sample_burst(input int count);
    longint u;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        1, 2: begin
          if (entries_stored != 0)
            u = longint'(cdf_keys[$urandom_range(0, entries_stored - 1)]) +
                longint'($urandom_range(0, 2)) - 1;
          else
            u = longint'($urandom());
        end
        3:       u = 0;
        4:       u = longint'(FX_ONE);
        5:       u = longint'(FX_ONE) + longint'($urandom());
        default: u = longint'($urandom());
      endcase
      if (u < 0) u = 0;
      send(make_item(OP_SAMPLE, random_fx(), 1'($urandom_range(0, 1)), u[FX_W-1:0]));
    end
  endtask

  // Receiver side: ready is redrawn at every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result checker: every result transaction is matched against the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    dcs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: index %0d status %0d entry_count %0d",
               out_data.index, out_data.status, out_data.entry_count);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.index !== want.index) begin
          $error("index: expected %0d, actual %0d", want.index, out_data.index);
          failures++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 want.entry_count, out_data.entry_count);
          failures++;
        end
      end
    end
  end

  initial begin
    seq_kind_e   kind;
    int          n;
    int          choice;
    int unsigned seq_count;

    // Directed part. Rows with typed results cover reset, errors and the
    // extremes; the rest follow the predictor.
    add_row(OP_SAMPLE, '0, 1'b0, '0, 1'b1, 8'd0, ST_NOT_READY, 9'd0);
    add_row(OP_LOAD, '1, 1'b0, '1, 1'b1, 8'd0, ST_OVER, 9'd0);
    add_row(OP_LOAD, 33'd1, 1'b0, '0, 1'b1, 8'd0, ST_NOT_READY, 9'd0);
    add_row(OP_SAMPLE, '1, 1'b1, ONE_FX, 1'b1, 8'd0, ST_NOT_READY, 9'd0);
    add_row(OP_CLEAR, '1, 1'b1, '1, 1'b1, 8'd0, ST_OK, 9'd0);
    add_row(OP_UNUSED, '1, 1'b1, '1, 1'b1, 8'd0, ST_OK, 9'd0);
    // A single weight just past 1.0 but inside the tolerance is clamped.
    add_row(OP_LOAD, ONE_FX + 33'd43, 1'b1, '0, 1'b1, 8'd0, ST_OK, 9'd1);
    add_row(OP_LOAD, 33'd5, 1'b1, '0, 1'b1, 8'd0, ST_NOT_READY, 9'd1);
    add_row(OP_SAMPLE, '0, 1'b0, '0, 1'b1, 8'd0, ST_OK, 9'd1);
    add_row(OP_SAMPLE, '0, 1'b0, '1, 1'b1, 8'd0, ST_OK, 9'd1);
    add_row(OP_CLEAR, '0, 1'b0, '0, 1'b1, 8'd0, ST_OK, 9'd0);
    // Zero weight first, then keys 1/4, 3/4, 1.0 - 43 and 1.0; the final
    // weight clamps to 1.0 again and its key is dropped as a duplicate.
    add_row(OP_LOAD, '0, 1'b0, '0, 1'b1, 8'd0, ST_OK, 9'd0);
    add_row(OP_LOAD, ONE_FX >> 2, 1'b0, '0, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_LOAD, ONE_FX >> 1, 1'b0, '0, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_LOAD, (ONE_FX >> 2) - 33'd43, 1'b0, '0, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_LOAD, 33'd43, 1'b0, '0, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_LOAD, 33'd20, 1'b1, '0, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_SAMPLE, '0, 1'b0, ONE_FX >> 2, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_SAMPLE, '0, 1'b0, (ONE_FX >> 2) - 33'd1, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_SAMPLE, '0, 1'b0, ONE_FX - 33'd44, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_SAMPLE, '0, 1'b0, ONE_FX - 33'd1, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_SAMPLE, '0, 1'b0, ONE_FX, 1'b0, 8'd0, ST_OK, 9'd0);
    add_row(OP_CLEAR, '0, 1'b0, '0, 1'b1, 8'd0, ST_OK, 9'd0);
    add_row(OP_LOAD, ONE_FX >> 1, 1'b1, '0, 1'b1, 8'd0, ST_UNDER, 9'd1);
    add_row(OP_SAMPLE, '0, 1'b0, 33'd1, 1'b1, 8'd0, ST_NOT_READY, 9'd1);

    // Reset is released at a falling edge.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      drive_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].result);

    // Full table: 256 distinct keys completing the load, then searches across it.
    set_idle_phase(3);
    send(make_item(OP_CLEAR, random_fx(), 1'b0, random_fx()));
    run_full_load();
    sample_burst(16);
    // Too many weights: 256 unmarked weights, then one more.
    send(make_item(OP_CLEAR, random_fx(), 1'b0, random_fx()));
    run_load(MAX_WEIGHTS, SEQ_OPEN);
    send(make_item(OP_LOAD, random_fx(), 1'b1, random_fx()));
    sample_burst(2);

    // Random part: mostly cleared, well-formed load sequences with random
    // content followed by samples, plus broken sequences and raw noise. The
    // flow-control phase rotates every few sequences.
    seq_count = 0;
    while (sent_items < 650) begin
      set_idle_phase((seq_count / 3) % 4);
      if ($urandom_range(0, 9) < 8) begin
        n      = ($urandom_range(0, 24) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 10);
        choice = $urandom_range(0, 9);
        case (choice)
          7:       kind = SEQ_SHORT;
          8:       kind = SEQ_OVERRUN;
          9:       kind = SEQ_OPEN;
          default: kind = SEQ_CLEAN;
        endcase
        send(make_item(OP_CLEAR, random_fx(), 1'($urandom_range(0, 1)), random_fx()));
        run_load(n, kind);
        sample_burst($urandom_range(1, 8));
      end else begin
        repeat ($urandom_range(1, 6))
          send(make_item(2'($urandom_range(0, 3)), random_fx(), 1'($urandom_range(0, 1)),
                         random_fx()));
      end
      seq_count++;
    end
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then keep watching the output to
    // catch anything extra the block might still emit.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
